### src/esc_pkg.sv
// Shared types, constants and helpers for the JSON string escaper.
// No dependencies.
package esc_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CTRL_MAX  = 8'h1f;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_SHORT,
    KIND_UNI
  } kind_t;

  // data: raw byte for pass and unicode forms, escape letter for short form
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       eos;
  } item_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_LOW_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

### src/esc_front.sv
// Front end: classifies one raw byte into its escape form.
// Depends on esc_pkg.
module esc_front (
  input  logic [7:0]     in_byte,
  input  logic           in_end_of_string,
  output esc_pkg::item_t item
);

  always_comb begin
    item.data = in_byte;
    item.eos  = in_end_of_string;
    item.kind = esc_pkg::KIND_PASS;
    unique case (in_byte)
      8'h08: begin
        item.kind = esc_pkg::KIND_SHORT;
        item.data = 8'h62;
      end
      8'h0a: begin
        item.kind = esc_pkg::KIND_SHORT;
        item.data = 8'h6e;
      end
      8'h0d: begin
        item.kind = esc_pkg::KIND_SHORT;
        item.data = 8'h72;
      end
      8'h09: begin
        item.kind = esc_pkg::KIND_SHORT;
        item.data = 8'h74;
      end
      esc_pkg::CH_BSLASH, esc_pkg::CH_QUOTE: begin
        item.kind = esc_pkg::KIND_SHORT;
      end
      default: begin
        if (in_byte != 8'h00 && in_byte <= esc_pkg::CTRL_MAX) begin
          item.kind = esc_pkg::KIND_UNI;
        end
      end
    endcase
  end

endmodule

### src/esc_fifo.sv
// Small register queue of classified items between front and back end.
// Depends on esc_pkg.
module esc_fifo #(
  parameter int unsigned DEPTH = esc_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  esc_pkg::item_t wr_item,
  output logic           is_full,
  input  logic           rd_en,
  output esc_pkg::item_t rd_item,
  output logic           is_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  esc_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic do_wr, do_rd;

  assign is_full  = (cnt_r == FULL_CNT);
  assign is_empty = (cnt_r == '0);
  assign do_wr    = wr_en && !is_full;
  assign do_rd    = rd_en && !is_empty;
  assign rd_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### src/esc_back.sv
// Back end: walks the queue head into the result register, one output byte per cycle unless pop stalls it.
// Depends on esc_pkg.
module esc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  esc_pkg::item_t head,
  input  logic           head_valid,
  output logic           head_pop,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  output logic           out_string_last,
  output logic           empty,
  input  logic           pop
);

  logic [2:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       run_last_r, string_last_r;
  logic       advance, seq_last;
  logic [7:0] seq_byte;

  assign advance  = !valid_r || pop;
  assign head_pop = advance && head_valid && seq_last;

  always_comb begin
    seq_byte = head.data;
    seq_last = 1'b1;
    unique case (head.kind)
      esc_pkg::KIND_SHORT: begin
        seq_last = (idx_r == 3'd1);
        seq_byte = (idx_r == 3'd0) ? esc_pkg::CH_BSLASH : head.data;
      end
      esc_pkg::KIND_UNI: begin
        seq_last = (idx_r == 3'd5);
        unique case (idx_r)
          3'd0:    seq_byte = esc_pkg::CH_BSLASH;
          3'd1:    seq_byte = esc_pkg::CH_U;
          3'd4:    seq_byte = esc_pkg::hex_digit(head.data[7:4]);
          3'd5:    seq_byte = esc_pkg::hex_digit(head.data[3:0]);
          default: seq_byte = esc_pkg::CH_ZERO;
        endcase
      end
      default: begin
        seq_last = 1'b1;
        seq_byte = head.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (advance) begin
      valid_r <= head_valid;
      if (head_valid) begin
        byte_r        <= seq_byte;
        run_last_r    <= seq_last;
        string_last_r <= seq_last && head.eos;
        idx_r         <= seq_last ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  assign empty           = !valid_r;
  assign out_byte        = byte_r;
  assign out_run_last    = run_last_r;
  assign out_string_last = string_last_r;

endmodule

### src/json_string_escaper.sv
// Top level of the JSON string escaper: front classifier, item queue, back serializer.
// Depends on esc_pkg, esc_front, esc_fifo, esc_back.
//
// Takes one raw string byte per push and delivers its JSON-escaped form, one output
// byte per pop, with run_last on the final byte of each input and string_last on the
// final byte of a string-ending input. The back serializer emits one byte per cycle
// unless pop stalls it: a pass-through byte gives one output byte, a short escape two
// and a \u00xx escape six, so plain text flows at one byte per cycle. FIFO_DEPTH
// classified bytes queue between the input and the serializer; full rises when that
// queue fills. A pushed byte passes the queue, then the result register, to the ports.
module json_string_escaper #(
  parameter int unsigned FIFO_DEPTH = esc_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_last
);

  esc_pkg::item_t front_item, head_item;
  logic q_empty, q_pop;

  esc_front u_front (
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .item             (front_item)
  );

  esc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_item  (front_item),
    .is_full  (full),
    .rd_en    (q_pop),
    .rd_item  (head_item),
    .is_empty (q_empty)
  );

  esc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head_item),
    .head_valid      (!q_empty),
    .head_pop        (q_pop),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last),
    .empty           (empty),
    .pop             (pop)
  );

endmodule

### src/esc_checker.sv
// Port-level assertions for the JSON string escaper, bound to the top level.
// Depends on json_string_escaper.
module esc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_string_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input queue full after reset");

  a_string_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_string_last |-> out_run_last)
    else $error("string_last without run_last");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && !out_run_last |=> !empty)
    else $error("escape sequence broken off");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_run_last)
                       && $stable(out_string_last))
    else $error("stalled request changed");

endmodule

bind json_string_escaper esc_checker u_esc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_byte        (out_byte),
  .out_run_last    (out_run_last),
  .out_string_last (out_string_last)
);

### sim/testbench.sv
// Testbench for json_string_escaper: drives raw string bytes, predicts the escaped
// byte stream and checks every popped byte. Depends only on the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_FF    = 8'h0c;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_QUOTE = 8'h22;
  localparam logic [7:0] BYTE_SLASH = 8'h5c;
  localparam logic [7:0] BYTE_DEL   = 8'h7f;
  localparam logic [7:0] CTRL_TOP   = 8'h1f;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam string HEX_CHARS = "0123456789abcdef";

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       string_last;
  } esc_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_last;

  esc_out_t    escaped_bytes[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;

  json_string_escaper u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_end_of_string(in_end_of_string),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // expected escaped form of one accepted byte
  function automatic void predict_escape(input logic [7:0] b, input logic eos);
    logic [7:0] seq[6];
    logic [7:0] letter;
    int         n;
    esc_out_t   e;
    letter = 8'h00;
    case (b)
      BYTE_BS:    letter = "b";
      BYTE_LF:    letter = "n";
      BYTE_CR:    letter = "r";
      BYTE_TAB:   letter = "t";
      BYTE_SLASH: letter = BYTE_SLASH;
      BYTE_QUOTE: letter = BYTE_QUOTE;
      default:    letter = 8'h00;
    endcase
    if (letter != 8'h00) begin
      seq[0] = BYTE_SLASH;
      seq[1] = letter;
      n = 2;
    end else if (b != 8'h00 && b <= CTRL_TOP) begin
      seq[0] = BYTE_SLASH;
      seq[1] = "u";
      seq[2] = "0";
      seq[3] = "0";
      seq[4] = HEX_CHARS[b[7:4]];
      seq[5] = HEX_CHARS[b[3:0]];
      n = 6;
    end else begin
      seq[0] = b;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      e.data        = seq[k];
      e.run_last    = (k == n - 1);
      e.string_last = (k == n - 1) ? eos : 1'b0;
      escaped_bytes.push_back(e);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push             <= 1'b1;
    in_byte          <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_escape(b, eos);
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned sel;
    logic [7:0]  specials[8];
    specials = '{BYTE_BS, BYTE_TAB, BYTE_LF, BYTE_FF, BYTE_CR, BYTE_QUOTE,
                 BYTE_SLASH, BYTE_DEL};
    sel = $urandom_range(99);
    if (sel < 35) return 8'($urandom_range(8'h20, 8'h7e));
    if (sel < 60) return 8'($urandom_range(0, CTRL_TOP));
    if (sel < 75) return specials[$urandom_range(7)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_corner_bytes();
    logic [7:0] corners[20];
    corners = '{8'h00, 8'hff, BYTE_DEL, 8'h80, BYTE_BS, BYTE_LF, BYTE_CR, BYTE_TAB,
                BYTE_SLASH, BYTE_QUOTE, BYTE_FF, 8'h01, CTRL_TOP, 8'h20, 8'h10,
                8'h1a, 8'h41, 8'h2f, 8'h55, 8'haa};
    for (int i = 0; i < 20; i++) begin
      send_byte(corners[i], i[0]);
    end
  endtask

  // strings of random length, the last byte flagged; some loose bytes with a random flag
  task automatic test_random_strings(input int unsigned n_items, input int unsigned idle,
                                     input int unsigned stall);
    int unsigned sent;
    int unsigned len;
    send_idle_pct = idle;
    pop_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_byte(pick_byte(), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_byte(pick_byte(), i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    esc_out_t e;
    if (rst_n && pop && !empty) begin
      if (escaped_bytes.size() == 0) begin
        $error("unexpected result out_byte %h", out_byte);
        error_count++;
      end else begin
        e = escaped_bytes.pop_front();
        if (out_byte !== e.data) begin
          $error("out_byte expected %h actual %h", e.data, out_byte);
          error_count++;
        end
        if (out_run_last !== e.run_last) begin
          $error("out_run_last expected %b actual %b", e.run_last, out_run_last);
          error_count++;
        end
        if (out_string_last !== e.string_last) begin
          $error("out_string_last expected %b actual %b", e.string_last,
                 out_string_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_bytes();
    test_random_strings(112, 0, 0);
    test_random_strings(112, 51, 0);
    test_random_strings(112, 0, 51);
    test_random_strings(112, 22, 22);
    push <= 1'b0;
    pop_stall_pct = 0;
    while (escaped_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
